>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion sampled on the rising edge, off while reset is high
`define RBF_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rbf assertion failed");

// concurrent assertion that also checks behavior around reset
`define RBF_ASSERT_RST(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("rbf reset assertion failed");

`endif

>>> rtl/rbf_pkg.sv
// types and constants for the reconnect backoff state machine
`default_nettype none

package rbf_pkg;

  // link states
  localparam logic [2:0] ST_DISC  = 3'd0;
  localparam logic [2:0] ST_CONN  = 3'd1;
  localparam logic [2:0] ST_AUTH  = 3'd2;
  localparam logic [2:0] ST_ENTER = 3'd3;
  localparam logic [2:0] ST_UP    = 3'd4;
  localparam logic [2:0] ST_RECON = 3'd5;
  localparam logic [2:0] ST_FAIL  = 3'd6;

  // event codes carried by a request
  localparam logic [3:0] EV_CONNECT     = 4'd0;
  localparam logic [3:0] EV_CONNECTED   = 4'd1;
  localparam logic [3:0] EV_AUTH_OK     = 4'd2;
  localparam logic [3:0] EV_ENTERED     = 4'd3;
  localparam logic [3:0] EV_DROPPED     = 4'd4;
  localparam logic [3:0] EV_ATTEMPT     = 4'd5;
  localparam logic [3:0] EV_ATT_FAILED  = 4'd6;
  localparam logic [3:0] EV_GAVE_UP     = 4'd7;
  localparam logic [3:0] EV_FATAL       = 4'd8;
  localparam logic [3:0] EV_RESET       = 4'd9;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROWTH_FACTOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_CAP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT  = 3'd4;

  // running product of growth factors, unsigned Q32.16
  localparam logic [47:0] PROD_ONE = 48'h0000_0001_0000;
  localparam logic [47:0] PROD_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] ATT_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [31:0] base_delay;
    logic [15:0] growth_factor;
    logic [31:0] delay_cap;
    logic [15:0] attempt_limit;
    logic [31:0] window_limit;
  } cfg_t;

  localparam cfg_t CFG_DEFAULT = '{
    base_delay:    32'd1000,
    growth_factor: 16'd512,
    delay_cap:     32'd30000,
    attempt_limit: 16'd0,
    window_limit:  32'd0
  };

endpackage

`default_nettype wire

>>> rtl/rbf_req_if.sv
// request channel: one connection event and the elapsed episode time
`default_nettype none

interface rbf_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [31:0] elapsed_ms;

  modport source (output valid, output req_type, output elapsed_ms, input ready);
  modport sink   (input valid, input req_type, input elapsed_ms, output ready);
  modport mon    (input valid, input req_type, input elapsed_ms, input ready);
endinterface

`default_nettype wire

>>> rtl/rbf_rsp_if.sv
// response channel: result of one connection event
`default_nettype none

interface rbf_rsp_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [2:0]  link_state;
  logic [15:0] attempt_count;
  logic [31:0] backoff_ms;
  logic        was_up;

  modport source (output valid, output accepted, output link_state, output attempt_count,
                  output backoff_ms, output was_up, input ready);
  modport sink   (input valid, input accepted, input link_state, input attempt_count,
                  input backoff_ms, input was_up, output ready);
  modport mon    (input valid, input accepted, input link_state, input attempt_count,
                  input backoff_ms, input was_up, input ready);
endinterface

`default_nettype wire

>>> rtl/rbf_backoff.sv
// backoff arithmetic: delay from the running product and the next product step
`default_nettype none

module rbf_backoff (
  input  rbf_pkg::cfg_t cfg,
  input  logic [47:0]   product,
  output logic [31:0]   delay,
  output logic [47:0]   product_step
);
  import rbf_pkg::*;

  logic [63:0] whole;
  logic [47:0] frac_full;
  logic [64:0] total;
  logic [63:0] grown;
  logic [55:0] grown_shr;

  // delay = base * product / 2^16, clamped to the cap
  assign whole     = {32'd0, cfg.base_delay} * {32'd0, product[47:16]};
  assign frac_full = {16'd0, cfg.base_delay} * {32'd0, product[15:0]};
  assign total     = {1'b0, whole} + {33'd0, frac_full[47:16]};
  assign delay     = (total >= {33'd0, cfg.delay_cap}) ? cfg.delay_cap : total[31:0];

  // next product = product * factor / 2^8, saturating at 48 bits
  assign grown        = {16'd0, product} * {48'd0, cfg.growth_factor};
  assign grown_shr    = grown[63:8];
  assign product_step = (grown_shr[55:48] != 8'd0) ? PROD_MAX : grown_shr[47:0];

endmodule

`default_nettype wire

>>> rtl/reconnect_backoff_fsm_core.sv
// reconnect backoff state machine, top level
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+----------------------------------------------
//  req     | in  | valid/ready   | req_type, elapsed_ms
//  rsp     | out | valid/ready   | accepted, link_state, attempt_count,
//          |     |               | backoff_ms, was_up
//  cfg     | in  | cfg_wr_en     | cfg_addr, cfg_wdata
//
// one request per cycle sustained while results are taken; a taken request passes the input
// register, then the state update loads the result register
// the state update, including the backoff multipliers, is combinational
// rst is synchronous: it clears the state, the handshake flags and the configuration registers
// a waiting result does not block intake: one more request is held in the input register
`default_nettype none

module reconnect_backoff_fsm_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [rbf_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [rbf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  rbf_req_if.sink                          req,
  rbf_rsp_if.source                        rsp
);
  import rbf_pkg::*;

  cfg_t        cfg;

  logic        in_valid;
  logic [3:0]  in_type;
  logic [31:0] in_elapsed;
  logic        fire;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic [15:0] attempts;
  logic [15:0] attempts_next;
  logic [31:0] pending;
  logic [31:0] pending_next;
  logic [47:0] product;
  logic [47:0] product_next;
  logic        been_up;
  logic        been_up_next;
  logic        ok;

  logic        out_valid;
  logic        out_accepted;

  logic [31:0] delay_now;
  logic [47:0] product_step;
  logic [31:0] delay_first;
  logic        spent;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_DEFAULT;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_BASE_DELAY:    cfg.base_delay    <= cfg_wdata;
        REG_GROWTH_FACTOR: cfg.growth_factor <= cfg_wdata[15:0];
        REG_DELAY_CAP:     cfg.delay_cap     <= cfg_wdata;
        REG_ATTEMPT_LIMIT: cfg.attempt_limit <= cfg_wdata[15:0];
        REG_WINDOW_LIMIT:  cfg.window_limit  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake: process when the result register is free or being emptied
  assign fire      = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_type    <= req.req_type;
      in_elapsed <= req.elapsed_ms;
    end
  end

  // backoff multipliers
  rbf_backoff u_backoff (
    .cfg          (cfg),
    .product      (product),
    .delay        (delay_now),
    .product_step (product_step)
  );

  // delay at episode start, with the product at one
  assign delay_first = (cfg.base_delay >= cfg.delay_cap) ? cfg.delay_cap : cfg.base_delay;

  // attempt and time budget
  assign spent = ((cfg.attempt_limit != 16'd0) && (attempts >= cfg.attempt_limit)) ||
                 ((cfg.window_limit != 32'd0) && (in_elapsed >= cfg.window_limit));

  // link state machine
  always_comb begin
    state_next   = state;
    attempts_next = attempts;
    pending_next = pending;
    product_next = product;
    been_up_next = been_up;
    ok           = 1'b0;
    case (in_type)
      EV_RESET: begin
        state_next    = ST_DISC;
        attempts_next = 16'd0;
        pending_next  = 32'd0;
        product_next  = 48'd0;
        been_up_next  = 1'b0;
        ok            = 1'b1;
      end
      EV_FATAL: begin
        if (state != ST_FAIL && state != ST_DISC) begin
          state_next   = ST_FAIL;
          pending_next = 32'd0;
          ok           = 1'b1;
        end
      end
      EV_CONNECT, EV_CONNECTED, EV_AUTH_OK, EV_ENTERED, EV_DROPPED,
      EV_ATTEMPT, EV_ATT_FAILED, EV_GAVE_UP: begin
        case (state)
          ST_DISC: begin
            if (in_type == EV_CONNECT) begin
              state_next = ST_CONN;
              ok         = 1'b1;
            end
          end
          ST_CONN: begin
            if (in_type == EV_CONNECTED) begin
              state_next = ST_AUTH;
              ok         = 1'b1;
            end else if (in_type == EV_DROPPED) begin
              state_next = ST_DISC;
              ok         = 1'b1;
            end
          end
          ST_AUTH: begin
            if (in_type == EV_AUTH_OK) begin
              state_next = ST_ENTER;
              ok         = 1'b1;
            end else if (in_type == EV_DROPPED) begin
              state_next = ST_DISC;
              ok         = 1'b1;
            end
          end
          ST_ENTER: begin
            if (in_type == EV_ENTERED) begin
              state_next   = ST_UP;
              been_up_next = 1'b1;
              ok           = 1'b1;
            end else if (in_type == EV_DROPPED) begin
              ok = 1'b1;
              if (been_up) begin
                state_next    = ST_RECON;
                attempts_next = 16'd0;
                product_next  = PROD_ONE;
                pending_next  = delay_first;
              end else begin
                state_next = ST_DISC;
              end
            end
          end
          ST_UP: begin
            if (in_type == EV_DROPPED) begin
              state_next    = ST_RECON;
              attempts_next = 16'd0;
              product_next  = PROD_ONE;
              pending_next  = delay_first;
              ok            = 1'b1;
            end
          end
          ST_RECON: begin
            if (in_type == EV_ATTEMPT) begin
              ok = 1'b1;
              if (spent) begin
                state_next   = ST_FAIL;
                pending_next = 32'd0;
              end else begin
                if (attempts != ATT_MAX) begin
                  attempts_next = attempts + 16'd1;
                  product_next  = product_step;
                end
                pending_next = 32'd0;
              end
            end else if (in_type == EV_ENTERED) begin
              state_next   = ST_UP;
              been_up_next = 1'b1;
              pending_next = 32'd0;
              ok           = 1'b1;
            end else if (in_type == EV_ATT_FAILED) begin
              ok = 1'b1;
              if (spent) begin
                state_next   = ST_FAIL;
                pending_next = 32'd0;
              end else begin
                pending_next = delay_now;
              end
            end else if (in_type == EV_GAVE_UP) begin
              state_next   = ST_FAIL;
              pending_next = 32'd0;
              ok           = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_DISC;
      attempts <= 16'd0;
      pending  <= 32'd0;
      product  <= 48'd0;
      been_up  <= 1'b0;
    end else if (fire) begin
      state    <= state_next;
      attempts <= attempts_next;
      pending  <= pending_next;
      product  <= product_next;
      been_up  <= been_up_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_accepted <= ok;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.accepted      = out_accepted;
  assign rsp.link_state    = state;
  assign rsp.attempt_count = attempts;
  assign rsp.backoff_ms    = pending;
  assign rsp.was_up        = been_up;

endmodule

`default_nettype wire

>>> rtl/rbf_checker.sv
// port-level checks for the reconnect backoff state machine, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module rbf_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_accepted,
  input logic [2:0]  rsp_link_state,
  input logic [15:0] rsp_attempt_count,
  input logic [31:0] rsp_backoff_ms,
  input logic        rsp_was_up
);
  import rbf_pkg::*;

  logic [52:0] rsp_word;
  logic        counted_state;
  logic        live_state;

  // whole result payload and state groupings
  assign rsp_word      = {rsp_accepted, rsp_link_state, rsp_attempt_count,
                          rsp_backoff_ms, rsp_was_up};
  assign counted_state = rsp_link_state inside {ST_UP, ST_RECON, ST_FAIL};
  assign live_state    = rsp_link_state inside {ST_UP, ST_RECON};

  // no result right after reset
  `RBF_ASSERT_RST(a_rst_clears_valid, clk, rst |=> !rsp_valid)

  // a stalled result holds
  `RBF_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))

  // a pending backoff exists only while reconnecting
  `RBF_ASSERT(a_backoff_only_recon, clk, rst, rsp_valid && (rsp_backoff_ms != 32'd0) |-> rsp_link_state == ST_RECON)

  // attempts are counted only once the link has come up
  `RBF_ASSERT(a_attempts_state, clk, rst, rsp_valid && (rsp_attempt_count != 16'd0) |-> counted_state)

  // up and reconnecting imply the link has been up
  `RBF_ASSERT(a_was_up, clk, rst, rsp_valid && live_state |-> rsp_was_up)

endmodule

bind reconnect_backoff_fsm_core rbf_checker u_rbf_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_accepted      (rsp.accepted),
  .rsp_link_state    (rsp.link_state),
  .rsp_attempt_count (rsp.attempt_count),
  .rsp_backoff_ms    (rsp.backoff_ms),
  .rsp_was_up        (rsp.was_up)
);

`default_nettype wire

>>> tb/tb.sv
// testbench for the reconnect backoff state machine: predictor, scoreboard and stimulus
`timescale 1ns / 1ps

module tb;
  import rbf_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 125;
  localparam int PHASE_COUNT  = 8;
  localparam int HOLD_CYCLES  = 64;
  localparam int SAT_ATTEMPTS = 12;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  link_state;
    logic [15:0] attempt_count;
    logic [31:0] backoff_ms;
    logic        was_up;
  } outcome_t;

  // tracks link state and backoff for every taken request, queues the outcome
  class reconnect_tracker;
    cfg_t        regs;
    logic [2:0]  link;
    logic [15:0] tries;
    logic [31:0] delay;
    logic [47:0] product;
    logic        seen_up;
    outcome_t    due_q[$];
    int          errors;

    function new();
      regs    = CFG_DEFAULT;
      link    = ST_DISC;
      tries   = '0;
      delay   = '0;
      product = '0;
      seen_up = 1'b0;
      errors  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BASE_DELAY:    regs.base_delay    = data;
        REG_GROWTH_FACTOR: regs.growth_factor = data[15:0];
        REG_DELAY_CAP:     regs.delay_cap     = data;
        REG_ATTEMPT_LIMIT: regs.attempt_limit = data[15:0];
        REG_WINDOW_LIMIT:  regs.window_limit  = data;
        default: ;
      endcase
    endfunction

    // base times the Q32.16 product, clamped to the cap
    function logic [31:0] scaled_delay();
      logic [63:0] whole;
      logic [63:0] total;
      whole = {32'd0, regs.base_delay} * {32'd0, product[47:16]};
      if (whole >= {32'd0, regs.delay_cap}) return regs.delay_cap;
      total = whole + (({32'd0, regs.base_delay} * {48'd0, product[15:0]}) >> 16);
      if (total > {32'd0, regs.delay_cap}) total = {32'd0, regs.delay_cap};
      return total[31:0];
    endfunction

    function bit budget_gone(logic [31:0] elapsed);
      return (regs.attempt_limit != 0 && tries >= regs.attempt_limit) ||
             (regs.window_limit != 0 && elapsed >= regs.window_limit);
    endfunction

    function void open_episode();
      link    = ST_RECON;
      tries   = '0;
      product = PROD_ONE;
      delay   = scaled_delay();
    endfunction

    function void give_up();
      link  = ST_FAIL;
      delay = '0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // apply one taken request and queue the outcome it must produce
    function void take_event(logic [3:0] ev, logic [31:0] elapsed);
      logic [63:0] grown;
      logic        hit;
      hit = 1'b0;
      if (ev == EV_RESET) begin
        link    = ST_DISC;
        tries   = '0;
        delay   = '0;
        product = '0;
        seen_up = 1'b0;
        hit     = 1'b1;
      end else if (ev == EV_FATAL) begin
        if (link != ST_FAIL && link != ST_DISC) begin
          give_up();
          hit = 1'b1;
        end
      end else if (ev < EV_RESET) begin
        case (link)
          ST_DISC: if (ev == EV_CONNECT) begin
            link = ST_CONN;
            hit  = 1'b1;
          end
          ST_CONN: begin
            if (ev == EV_CONNECTED) begin
              link = ST_AUTH;
              hit  = 1'b1;
            end else if (ev == EV_DROPPED) begin
              link = ST_DISC;
              hit  = 1'b1;
            end
          end
          ST_AUTH: begin
            if (ev == EV_AUTH_OK) begin
              link = ST_ENTER;
              hit  = 1'b1;
            end else if (ev == EV_DROPPED) begin
              link = ST_DISC;
              hit  = 1'b1;
            end
          end
          ST_ENTER: begin
            if (ev == EV_ENTERED) begin
              link    = ST_UP;
              seen_up = 1'b1;
              hit     = 1'b1;
            end else if (ev == EV_DROPPED) begin
              if (seen_up) open_episode();
              else link = ST_DISC;
              hit = 1'b1;
            end
          end
          ST_UP: if (ev == EV_DROPPED) begin
            open_episode();
            hit = 1'b1;
          end
          ST_RECON: begin
            hit = 1'b1;
            case (ev)
              EV_ATTEMPT: begin
                if (budget_gone(elapsed)) begin
                  give_up();
                end else begin
                  // full counter keeps both count and product
                  if (tries != ATT_MAX) begin
                    grown = ({16'd0, product} * {48'd0, regs.growth_factor}) >> 8;
                    tries++;
                    product = (grown > {16'd0, PROD_MAX}) ? PROD_MAX : grown[47:0];
                  end
                  delay = '0;
                end
              end
              EV_ENTERED: begin
                link    = ST_UP;
                seen_up = 1'b1;
                delay   = '0;
              end
              EV_ATT_FAILED: begin
                if (budget_gone(elapsed)) give_up();
                else delay = scaled_delay();
              end
              EV_GAVE_UP: give_up();
              default: hit = 1'b0;
            endcase
          end
          default: ;
        endcase
      end
      due_q.push_back('{accepted: hit, link_state: link, attempt_count: tries,
                        backoff_ms: delay, was_up: seen_up});
    endfunction

    function void compare(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      end
    endfunction

    // compare one response with the oldest outstanding outcome
    function void match_outcome(outcome_t got);
      outcome_t want;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected response, expected none actual %h", $time, got);
        return;
      end
      want = due_q.pop_front();
      compare("accepted", 32'(want.accepted), 32'(got.accepted));
      compare("link_state", 32'(want.link_state), 32'(got.link_state));
      compare("attempt_count", 32'(want.attempt_count), 32'(got.attempt_count));
      compare("backoff_ms", want.backoff_ms, got.backoff_ms);
      compare("was_up", 32'(want.was_up), 32'(got.was_up));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    calm = 1'b0;
  bit                    hold_off_req = 1'b0;
  int                    offered = 0;
  int                    quiet_cycles = 0;
  reconnect_tracker      book = new();

  rbf_req_if req_ch ();
  rbf_rsp_if rsp_ch ();

  reconnect_backoff_fsm_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #4 clk = ~clk;

  // response side: random stalls, calm stretches and one long hold-off
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        rsp_ch.ready <= calm || ($urandom_range(99) >= 37);
      end
    end
  end

  // watch register writes and both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wr_en) book.write_reg(cfg_addr, cfg_wdata);
      if (rsp_ch.valid && rsp_ch.ready)
        book.match_outcome('{accepted: rsp_ch.accepted, link_state: rsp_ch.link_state,
                             attempt_count: rsp_ch.attempt_count,
                             backoff_ms: rsp_ch.backoff_ms, was_up: rsp_ch.was_up});
      if (req_ch.valid && req_ch.ready) book.take_event(req_ch.req_type, req_ch.elapsed_ms);
    end
  end

  // watchdog on cycles with no progress
  always @(posedge clk) begin
    if (rst || cfg_wr_en || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // present one request until taken, then maybe idle a little
  task automatic offer(input logic [3:0] ev, input logic [31:0] el);
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= ev;
    req_ch.elapsed_ms <= el;
    do @(posedge clk); while (!req_ch.ready);
    offered++;
    if (!calm && $urandom_range(99) < 37) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // intended request, sometimes preceded by a stray event
  task automatic offer_mix(input logic [3:0] ev, input logic [31:0] el);
    logic [3:0] junk;
    junk = 4'($urandom_range(0, 15));
    if ($urandom_range(99) < 6) offer(junk, $urandom);
    offer(ev, el);
  endtask

  // stop sending and wait for every outstanding response
  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  task automatic program_cfg(input cfg_t s);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_BASE_DELAY;
    cfg_wdata <= s.base_delay;
    @(posedge clk);
    cfg_addr  <= REG_GROWTH_FACTOR;
    cfg_wdata <= {16'd0, s.growth_factor};
    @(posedge clk);
    cfg_addr  <= REG_DELAY_CAP;
    cfg_wdata <= s.delay_cap;
    @(posedge clk);
    cfg_addr  <= REG_ATTEMPT_LIMIT;
    cfg_wdata <= {16'd0, s.attempt_limit};
    @(posedge clk);
    cfg_addr  <= REG_WINDOW_LIMIT;
    cfg_wdata <= s.window_limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one connection life: link-up, reconnect episodes, then mostly a reset; some lives are stray events or drop early
  task automatic play_session();
    logic [31:0] t;
    int          pick;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 6)) offer(4'($urandom_range(0, 15)), $urandom);
      return;
    end
    pick = $urandom_range(0, 9);
    offer_mix(EV_CONNECT, $urandom);
    if (pick == 0) begin
      offer_mix(EV_DROPPED, $urandom);
    end else begin
      offer_mix(EV_CONNECTED, $urandom);
      if (pick == 1) begin
        offer_mix(EV_DROPPED, $urandom);
      end else begin
        offer_mix(EV_AUTH_OK, $urandom);
        if (pick == 2) begin
          offer_mix(EV_DROPPED, $urandom);
        end else begin
          offer_mix(EV_ENTERED, $urandom);
          repeat ($urandom_range(1, 3)) begin
            offer_mix(EV_DROPPED, $urandom);
            t = ($urandom_range(99) < 5) ? $urandom : 32'($urandom_range(0, 3000));
            repeat ($urandom_range(0, 10)) begin
              offer_mix(EV_ATTEMPT, t);
              t += $urandom_range(0, 900);
              offer_mix(EV_ATT_FAILED, t);
              t += $urandom_range(0, 900);
            end
            case ($urandom_range(0, 3))
              0, 1: offer_mix(EV_ENTERED, t);
              2: offer_mix(EV_GAVE_UP, t);
              default: offer_mix(EV_FATAL, t);
            endcase
          end
        end
      end
    end
    if ($urandom_range(99) < 85) offer_mix(EV_RESET, $urandom);
  endtask

  initial begin
    cfg_t setting;
    int   phase;
    int   start;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = EV_CONNECT;
    req_ch.elapsed_ms = '0;
    cfg_wr_en         = 1'b0;
    cfg_addr          = REG_BASE_DELAY;
    cfg_wdata         = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed walk with the reset register values
    offer(4'hF, 32'h0);
    offer(EV_FATAL, 32'hFFFF_FFFF);
    offer(EV_CONNECT, 32'h0);
    offer(EV_DROPPED, 32'h0);
    offer(EV_CONNECT, 32'h0);
    offer(EV_CONNECTED, 32'h0);
    offer(EV_DROPPED, 32'h0);
    offer(EV_CONNECT, 32'h0);
    offer(EV_CONNECTED, 32'h0);
    offer(EV_AUTH_OK, 32'h0);
    offer(EV_ATTEMPT, 32'h0);
    offer(EV_ENTERED, 32'h0);
    offer(EV_CONNECT, 32'h0);
    offer(EV_DROPPED, 32'h0);
    offer(EV_ATTEMPT, 32'h0);
    offer(EV_ATT_FAILED, 32'hFFFF_FFFF);
    offer(EV_ATTEMPT, 32'hFFFF_FFFF);
    offer(EV_ENTERED, 32'h0);
    offer(EV_DROPPED, 32'h0);
    offer(EV_GAVE_UP, 32'h0);
    offer(EV_FATAL, 32'h0);
    offer(EV_RESET, 32'h0);
    offer(EV_CONNECT, 32'h0);
    offer(EV_FATAL, 32'h0);
    offer(EV_RESET, 32'h0);
    settle();

    // random sessions under a series of register settings
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: setting = CFG_DEFAULT;
        1: setting = '1;
        2: setting = '0;
        3: setting = '{base_delay: 32'd1, growth_factor: 16'd256, delay_cap: 32'h7FFF_FFFF,
                       attempt_limit: 16'd1, window_limit: 32'd1};
        default: begin
          setting.base_delay    = $urandom_range(1) ? $urandom : 32'($urandom_range(0, 5000));
          setting.growth_factor = $urandom_range(1) ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(0, 1024));
          setting.delay_cap     = $urandom_range(1) ? $urandom : 32'($urandom_range(0, 60000));
          setting.attempt_limit = 16'($urandom_range(0, 12));
          setting.window_limit  = 32'($urandom_range(0, 20000));
        end
      endcase
      program_cfg(setting);
      calm = (phase == 5);
      if (phase == 2) hold_off_req = 1'b1;
      start = offered;
      while (offered - start < PHASE_ITEMS) play_session();
      settle();
    end

    // drive the product into saturation with the largest factor
    calm = 1'b1;
    program_cfg('{base_delay: 32'd3, growth_factor: 16'hFFFF, delay_cap: 32'hFFFF_FFFF,
                  attempt_limit: 16'd0, window_limit: 32'd0});
    offer(EV_RESET, $urandom);
    offer(EV_CONNECT, $urandom);
    offer(EV_CONNECTED, $urandom);
    offer(EV_AUTH_OK, $urandom);
    offer(EV_ENTERED, $urandom);
    offer(EV_DROPPED, $urandom);
    repeat (SAT_ATTEMPTS) begin
      offer(EV_ATTEMPT, $urandom);
      offer(EV_ATT_FAILED, $urandom);
    end
    offer(EV_RESET, $urandom);
    settle();

    repeat (8) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
